### rtl/core/tcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions for the text console character writer
// Field widths, command codes and register indexes used by the core and its
// shared multiply-add unit.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int COL_W  = 8;
   localparam int ROW_W  = 6;
   localparam int ADDR_W = 14;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int KIND_W = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   // command codes on the result channel
   localparam logic [KIND_W-1:0] OP_WRITE  = 2'd0;
   localparam logic [KIND_W-1:0] OP_SCROLL = 2'd1;
   localparam logic [KIND_W-1:0] OP_REPORT = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXT_COLOR   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_COLS  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_ROWS  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WRAP_DISABLE = 2'd3;

   // character codes acted on
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_VTAB      = 8'd11;
   localparam logic [CHAR_W-1:0] CH_FORMFEED  = 8'd12;
   localparam logic [CHAR_W-1:0] CH_CR        = 8'd13;
   localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

   // result budget per character
   localparam logic [2:0] MAX_WRITES     = 3'd5;
   localparam logic [2:0] MAX_PRE_REPORT = 3'd6;

   localparam logic [ROW_W-1:0] MIN_ROWS = 6'd3;
   localparam logic [COL_W-1:0] COL_MAX  = 8'd255;
   localparam logic [ROW_W-1:0] ROW_MAX  = 6'd63;

   typedef struct packed {
      logic [ROW_W-1:0] factor_row;
      logic [COL_W-1:0] factor_cols;
      logic [COL_W-1:0] addend;
   } mac_op_type;

endpackage

`default_nettype wire

### rtl/core/text_console_char_writer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_char_writer: character stream to text buffer commands
// Keeps a cursor and turns each character into cell writes, scroll-up
// commands and a final cursor report for an external text buffer.
// ----------------------------------------------------------------------------
//
//  channel  ports                         direction  carries
//  req      req_valid/req_stall/req_*     in         one character code
//  rsp      rsp_valid/rsp_stall/rsp_*     out        write, scroll or report
//  csr      csr_write/csr_index/csr_data  in         color, size, wrap control
//
//  one character at a time; req_stall is high from the transfer until the
//  cursor report has been loaded into the output register
//  a printable character passes the size, write, wrap, scroll and report
//  states, a control code skips write, a tab stays in write per blank and
//  each scroll row adds a scroll pass; wrap off skips the scroll check; the
//  single multiply-add unit gives addresses and screen size, one per cycle
//  rsp_stall holds the sequencer only on cycles that load a command
//  reset clears the cursor and loads color 7, 80 columns, 25 rows, wrap on
//
module text_console_char_writer #(
   parameter int TAB_STOP = 5
) (
   input  var logic                           clock,
   input  var logic                           reset,

   input  var logic                           req_valid,
   output logic                               req_stall,
   input  var logic [tcw_pkg::CHAR_W-1:0]     req_char_code,

   output logic                               rsp_valid,
   input  var logic                           rsp_stall,
   output logic [tcw_pkg::KIND_W-1:0]         rsp_op_kind,
   output logic [tcw_pkg::ADDR_W-1:0]         rsp_cell_address,
   output logic [tcw_pkg::CHAR_W-1:0]         rsp_cell_char,
   output logic [tcw_pkg::ATTR_W-1:0]         rsp_cell_attr,
   output logic [tcw_pkg::COL_W-1:0]          rsp_cursor_col_out,
   output logic [tcw_pkg::ROW_W-1:0]          rsp_cursor_row_out,
   output logic                               rsp_last_result,

   input  var logic                           csr_write,
   input  var logic [tcw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  var logic [tcw_pkg::CSR_DATA_W-1:0] csr_data
);
   import tcw_pkg::*;

   localparam int TAB_W = $clog2(TAB_STOP + 1);
   localparam logic [TAB_W-1:0] TAB_LAST = TAB_W'(TAB_STOP - 1);
   localparam logic [TAB_W-1:0] TAB_FULL = TAB_W'(TAB_STOP);

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SIZE   = 3'd1;
   localparam logic [2:0] ST_WRITE  = 3'd2;
   localparam logic [2:0] ST_WRAP   = 3'd3;
   localparam logic [2:0] ST_SCROLL = 3'd4;
   localparam logic [2:0] ST_REPORT = 3'd5;

   // configuration registers
   logic [ATTR_W-1:0] color_ff;
   logic [COL_W-1:0]  cols_ff;
   logic [ROW_W-1:0]  rows_ff;
   logic              wrap_dis_ff;

   // sequencer and cursor
   logic [2:0]        state_ff,   state_in;
   logic [COL_W-1:0]  col_ff,     col_in;
   logic [ROW_W-1:0]  row_ff,     row_in;
   logic [TAB_W-1:0]  col_mod_ff, col_mod_in;   // column modulo TAB_STOP
   logic [TAB_W-1:0]  tab_left_ff, tab_left_in;
   logic [2:0]        count_ff,   count_in;     // writes and scrolls loaded this character
   logic [CHAR_W-1:0] char_ff,    char_in;
   logic [ADDR_W-1:0] cap_ff,     cap_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] kind_ff,  kind_in;
   logic [ADDR_W-1:0] addr_ff,  addr_in;
   logic [CHAR_W-1:0] cchar_ff, cchar_in;
   logic [ATTR_W-1:0] attr_ff,  attr_in;
   logic [COL_W-1:0]  ocol_ff,  ocol_in;
   logic [ROW_W-1:0]  orow_ff,  orow_in;
   logic              last_ff,  last_in;

   logic [ROW_W-1:0]  rows_eff;
   logic              is_tab;
   logic              slot_free;
   logic              emit_go;
   logic [COL_W-1:0]  col_next;
   logic [TAB_W-1:0]  mod_next;
   logic [ROW_W:0]    row_plus1, row_plus4;
   logic [ROW_W-1:0]  row_sat1, row_sat4;
   mac_op_type        mac_op;
   logic [ADDR_W-1:0] mac_result;

   tcw_mac u_mac (
      .op     (mac_op),
      .result (mac_result)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff    <= 8'd7;
         cols_ff     <= 8'd80;
         rows_ff     <= 6'd25;
         wrap_dis_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TEXT_COLOR:   color_ff    <= csr_data;
            CSR_SCREEN_COLS:  cols_ff     <= csr_data;
            CSR_SCREEN_ROWS:  rows_ff     <= csr_data[ROW_W-1:0];
            CSR_WRAP_DISABLE: wrap_dis_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      // fewer than three rows behaves as three
      rows_eff  = (rows_ff < MIN_ROWS) ? MIN_ROWS : rows_ff;
      is_tab    = (char_ff == CH_TAB);
      slot_free = !rsp_valid_ff || !rsp_stall;

      // saturating column step, residue follows unless pinned at the top
      col_next = (col_ff == COL_MAX) ? COL_MAX : col_ff + 8'd1;
      if (col_ff == COL_MAX) begin
         mod_next = col_mod_ff;
      end else begin
         mod_next = (col_mod_ff == TAB_LAST) ? '0 : col_mod_ff + TAB_W'(1);
      end

      row_plus1 = {1'b0, row_ff} + 7'd1;
      row_plus4 = {1'b0, row_ff} + 7'd4;
      row_sat1  = row_plus1[ROW_W] ? ROW_MAX : row_plus1[ROW_W-1:0];
      row_sat4  = row_plus4[ROW_W] ? ROW_MAX : row_plus4[ROW_W-1:0];
   end

   always_comb begin
      state_in    = state_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      col_mod_in  = col_mod_ff;
      tab_left_in = tab_left_ff;
      count_in    = count_ff;
      char_in     = char_ff;
      cap_in      = cap_ff;
      emit_go     = 1'b0;

      kind_in  = kind_ff;
      addr_in  = addr_ff;
      cchar_in = cchar_ff;
      attr_in  = attr_ff;
      ocol_in  = ocol_ff;
      orow_in  = orow_ff;
      last_in  = last_ff;

      // default operands: address of the cursor cell
      mac_op.factor_row  = row_ff;
      mac_op.factor_cols = cols_ff;
      mac_op.addend      = col_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               char_in  = req_char_code;
               count_in = '0;
               state_in = ST_SIZE;
            end
         end

         ST_SIZE: begin
            // screen size in cells, then act on control codes
            mac_op.factor_row = rows_eff;
            mac_op.addend     = '0;
            cap_in            = mac_result;
            state_in          = ST_WRAP;
            case (char_ff)
               CH_NEWLINE: begin
                  col_in     = '0;
                  col_mod_in = '0;
                  row_in     = row_sat1;
               end
               CH_CR: begin
                  col_in     = '0;
                  col_mod_in = '0;
               end
               CH_BACKSPACE: begin
                  if (col_ff != '0) begin
                     col_in     = col_ff - 8'd1;
                     col_mod_in = (col_mod_ff == '0) ? TAB_LAST : col_mod_ff - TAB_W'(1);
                  end
               end
               CH_VTAB:     row_in = row_sat4;
               CH_FORMFEED: row_in = row_sat1;
               CH_TAB: begin
                  tab_left_in = TAB_FULL - col_mod_ff;
                  state_in    = ST_WRITE;
               end
               default:     state_in = ST_WRITE;
            endcase
         end

         ST_WRITE: begin
            // one cell per cycle while the output slot is free; dropped writes still move the cursor
            if (mac_result < cap_ff && (!is_tab || count_ff < MAX_WRITES)) begin
               if (slot_free) begin
                  emit_go  = 1'b1;
                  kind_in  = OP_WRITE;
                  addr_in  = mac_result;
                  cchar_in = is_tab ? CH_BLANK : char_ff;
                  ocol_in  = col_next;
                  orow_in  = row_ff;
                  last_in  = 1'b0;
                  count_in = count_ff + 3'd1;
               end
            end else begin
               emit_go = 1'b0;
            end
            if (emit_go || !(mac_result < cap_ff && (!is_tab || count_ff < MAX_WRITES))) begin
               col_in      = col_next;
               col_mod_in  = mod_next;
               tab_left_in = tab_left_ff - TAB_W'(1);
               if (!is_tab || tab_left_ff == TAB_W'(1)) begin
                  state_in = ST_WRAP;
               end
            end
         end

         ST_WRAP: begin
            if (!wrap_dis_ff) begin
               if (col_ff >= cols_ff) begin
                  col_in     = '0;
                  col_mod_in = '0;
                  row_in     = row_sat1;
               end
               state_in = ST_SCROLL;
            end else begin
               state_in = ST_REPORT;
            end
         end

         ST_SCROLL: begin
            // first blanked cell sits at the start of row rows-3
            mac_op.factor_row = rows_eff - 6'd3;
            mac_op.addend     = '0;
            if (row_ff >= rows_eff - 6'd2) begin
               if (count_ff < MAX_PRE_REPORT) begin
                  if (slot_free) begin
                     emit_go  = 1'b1;
                     kind_in  = OP_SCROLL;
                     addr_in  = mac_result;
                     cchar_in = CH_BLANK;
                     ocol_in  = col_ff;
                     orow_in  = row_ff - 6'd1;
                     last_in  = 1'b0;
                     count_in = count_ff + 3'd1;
                     row_in   = row_ff - 6'd1;
                  end
               end else begin
                  row_in = row_ff - 6'd1;
               end
            end else begin
               state_in = ST_REPORT;
            end
         end

         ST_REPORT: begin
            if (slot_free) begin
               emit_go  = 1'b1;
               kind_in  = OP_REPORT;
               addr_in  = mac_result;
               cchar_in = '0;
               ocol_in  = col_ff;
               orow_in  = row_ff;
               last_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      attr_in = emit_go ? color_ff : attr_ff;

      // output register: load on a new command, drain on a transfer
      if (emit_go) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         col_mod_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         col_mod_ff   <= col_mod_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      tab_left_ff <= tab_left_in;
      char_ff     <= char_in;
      cap_ff      <= cap_in;
      kind_ff     <= kind_in;
      addr_ff     <= addr_in;
      cchar_ff    <= cchar_in;
      attr_ff     <= attr_in;
      ocol_ff     <= ocol_in;
      orow_ff     <= orow_in;
      last_ff     <= last_in;
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_op_kind        = kind_ff;
   assign rsp_cell_address   = addr_ff;
   assign rsp_cell_char      = cchar_ff;
   assign rsp_cell_attr      = attr_ff;
   assign rsp_cursor_col_out = ocol_ff;
   assign rsp_cursor_row_out = orow_ff;
   assign rsp_last_result    = last_ff;

endmodule

`default_nettype wire

### rtl/core/tcw_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_mac: shared multiply-add unit
// Forms row * cols + column for cell addresses, the screen size and the
// first blanked cell of a scroll.
// ----------------------------------------------------------------------------
module tcw_mac (
   input  var tcw_pkg::mac_op_type          op,
   output logic [tcw_pkg::ADDR_W-1:0]       result
);
   import tcw_pkg::*;

   logic [ADDR_W-1:0] product;

   always_comb begin
      product = ADDR_W'(op.factor_row) * ADDR_W'(op.factor_cols);
      result  = product + ADDR_W'(op.addend);
   end

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the text console character writer
// Streams character codes through several screen settings while a shadow
// cursor predicts every cell write, scroll and cursor report. Each transfer
// on the result side is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
   import tcw_pkg::*;

   localparam int TAB_STOP     = 5;
   localparam int QUIET_CYCLES = 24;    // worst case: tab cells plus a long scroll run
   localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int MAX_SHOWN    = 10;

   // one command toward the text buffer, in the order of the result ports
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ADDR_W-1:0] addr;
      logic [CHAR_W-1:0] ch;
      logic [ATTR_W-1:0] attr;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic              last;
   } console_cmd_type;

   // receiver behavior, switched at random
   typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC} rx_mode_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [CHAR_W-1:0]      req_char_code = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [KIND_W-1:0]      rsp_op_kind;
   logic [ADDR_W-1:0]      rsp_cell_address;
   logic [CHAR_W-1:0]      rsp_cell_char;
   logic [ATTR_W-1:0]      rsp_cell_attr;
   logic [COL_W-1:0]       rsp_cursor_col_out;
   logic [ROW_W-1:0]       rsp_cursor_row_out;
   logic                   rsp_last_result;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   text_console_char_writer #(.TAB_STOP(TAB_STOP)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_code      (req_char_code),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_op_kind        (rsp_op_kind),
      .rsp_cell_address   (rsp_cell_address),
      .rsp_cell_char      (rsp_cell_char),
      .rsp_cell_attr      (rsp_cell_attr),
      .rsp_cursor_col_out (rsp_cursor_col_out),
      .rsp_cursor_row_out (rsp_cursor_row_out),
      .rsp_last_result    (rsp_last_result),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------------
   // shadow of the screen registers and the cursor
   // ------------------------------------------------------------------------
   logic [ATTR_W-1:0] shadow_color    = 8'd7;
   logic [COL_W-1:0]  shadow_cols     = 8'd80;
   logic [ROW_W-1:0]  shadow_rows     = 6'd25;
   logic              shadow_wrap_off = 1'b0;
   logic [COL_W-1:0]  cur_col = '0;
   logic [ROW_W-1:0]  cur_row = '0;

   console_cmd_type due_cmds[$];      // commands predicted but not yet seen
   int              cmds_this_char;
   int              mismatches = 0;

   function automatic int col_plus(input int c);
      return (c < COL_MAX) ? c + 1 : COL_MAX;
   endfunction

   function automatic int row_plus(input int r, input int k);
      return (r + k > ROW_MAX) ? ROW_MAX : r + k;
   endfunction

   function automatic void push_cmd(input logic [KIND_W-1:0] kind, input int addr,
                                    input logic [CHAR_W-1:0] ch, input int col,
                                    input int row, input logic last);
      console_cmd_type c;
      c.kind = kind;
      c.addr = ADDR_W'(addr);
      c.ch   = ch;
      c.attr = shadow_color;
      c.col  = COL_W'(col);
      c.row  = ROW_W'(row);
      c.last = last;
      due_cmds.push_back(c);
      cmds_this_char++;
   endfunction

   // works out the commands one character causes and moves the shadow cursor
   function automatic void console_step(input logic [CHAR_W-1:0] code);
      int col, row, rows, cols, cap, addr, span;
      col  = cur_col;
      row  = cur_row;
      rows = (shadow_rows < MIN_ROWS) ? MIN_ROWS : shadow_rows;
      cols = shadow_cols;
      cap  = rows * cols;
      cmds_this_char = 0;
      case (code)
         CH_NEWLINE: begin
            col = 0;
            row = row_plus(row, 1);
         end
         CH_CR:        col = 0;
         CH_BACKSPACE: if (col > 0) col--;
         CH_TAB: begin
            // blanks up to the next tab stop; only those on screen, up to MAX_WRITES, are sent
            span = TAB_STOP - (col % TAB_STOP);
            repeat (span) begin
               addr = row * cols + col;
               if (addr < cap && cmds_this_char < MAX_WRITES)
                  push_cmd(OP_WRITE, addr, CH_BLANK, col_plus(col), row, 1'b0);
               col = col_plus(col);
            end
         end
         CH_VTAB:     row = row_plus(row, 4);
         CH_FORMFEED: row = row_plus(row, 1);
         default: begin
            addr = row * cols + col;
            if (addr < cap)
               push_cmd(OP_WRITE, addr, code, col_plus(col), row, 1'b0);
            col = col_plus(col);
         end
      endcase
      if (!shadow_wrap_off) begin
         // one wrap at most, however far past the width
         if (col >= cols) begin
            col = 0;
            row = row_plus(row, 1);
         end
         // a row at or past rows-2 lands on rows-3, even when scrolls are not sent
         while (row >= rows - 2) begin
            row--;
            if (cmds_this_char < MAX_PRE_REPORT)
               push_cmd(OP_SCROLL, (rows - 3) * cols, CH_BLANK, col, row, 1'b0);
         end
      end
      push_cmd(OP_REPORT, row * cols + col, '0, col, row, 1'b1);
      cur_col = COL_W'(col);
      cur_row = ROW_W'(row);
   endfunction

   function automatic string describe(input console_cmd_type c);
      return $sformatf("kind=%0d addr=%0d char=%02h attr=%02h col=%0d row=%0d last=%0b",
                       c.kind, c.addr, c.ch, c.attr, c.col, c.row, c.last);
   endfunction

   // ------------------------------------------------------------------------
   // result side: every transfer is matched against the oldest prediction
   // ------------------------------------------------------------------------
   console_cmd_type seen_cmd;
   console_cmd_type want_cmd;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_cmd = {rsp_op_kind, rsp_cell_address, rsp_cell_char, rsp_cell_attr,
                     rsp_cursor_col_out, rsp_cursor_row_out, rsp_last_result};
         if (due_cmds.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
               $display("%t unexpected command: %s", $realtime, describe(seen_cmd));
         end else begin
            want_cmd = due_cmds.pop_front();
            if (seen_cmd !== want_cmd) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display("%t command mismatch\n   expected %s\n   actual   %s",
                           $realtime, describe(want_cmd), describe(seen_cmd));
            end
         end
      end
   end

   // receiver stall pattern: free running, random or periodic stretches,
   // plus a long hold-off whenever a test asks for one
   rx_mode_type rx_mode = RX_FREE;
   int          rx_mode_left = 0;
   int          rx_tick = 0;
   int          hold_left = 0;
   int          holds_asked = 0;
   int          holds_served = 0;

   always @(posedge clock) begin
      rx_tick++;
      if (holds_served != holds_asked) begin
         holds_served++;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_type'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(20, 200);
         end
         rx_mode_left--;
         case (rx_mode)
            RX_FREE:     rsp_stall <= 1'b0;
            RX_RANDOM:   rsp_stall <= ($urandom_range(0, 99) < 40);
            RX_PERIODIC: rsp_stall <= (rx_tick % 3 == 2);
            default:     rsp_stall <= 1'b0;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // sender side
   // ------------------------------------------------------------------------
   int burst_left = 0;

   // offers one character in bursts with random gaps, then predicts its
   // commands at the edge where the transfer happens
   task automatic send_char(input logic [CHAR_W-1:0] code);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_char_code <= code;
      do @(posedge clock); while (req_stall);
      console_step(code);
   endtask

   // drops valid and waits until every predicted command has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (due_cmds.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // rewrites all four screen registers while the block is idle
   task automatic program_screen(input logic [7:0] color, input logic [7:0] cols,
                                 input logic [5:0] rows, input logic wrap_off);
      wait_idle();
      csr_write <= 1'b1;
      csr_index <= CSR_TEXT_COLOR;
      csr_data  <= color;
      @(posedge clock);
      csr_index <= CSR_SCREEN_COLS;
      csr_data  <= cols;
      @(posedge clock);
      csr_index <= CSR_SCREEN_ROWS;
      csr_data  <= {2'b00, rows};
      @(posedge clock);
      csr_index <= CSR_WRAP_DISABLE;
      csr_data  <= {7'b0, wrap_off};
      @(posedge clock);
      csr_write <= 1'b0;
      shadow_color    = color;
      shadow_cols     = cols;
      shadow_rows     = rows;
      shadow_wrap_off = wrap_off;
   endtask

   // text with the control codes mixed in, some raw bytes
   function automatic logic [CHAR_W-1:0] pick_char();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return CHAR_W'($urandom_range(8'h20, 8'hff));
      if (roll < 55) return CH_TAB;
      if (roll < 65) return CH_NEWLINE;
      if (roll < 70) return CH_CR;
      if (roll < 76) return CH_BACKSPACE;
      if (roll < 80) return CH_VTAB;
      if (roll < 85) return CH_FORMFEED;
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // reset settings: byte extremes, every control code, backspace at the
   // left edge, tabs from an aligned and an unaligned column, scrolling
   task automatic test_control_codes();
      send_char(8'h00);
      send_char(8'hff);
      send_char(8'h41);
      repeat (4) send_char(CH_BACKSPACE);   // last one stops at column 0
      send_char(CH_TAB);                    // five blanks
      send_char(8'h78);
      send_char(CH_TAB);                    // four blanks from column 6
      send_char(CH_CR);
      send_char(CH_NEWLINE);
      repeat (5) send_char(CH_VTAB);
      repeat (2) send_char(CH_FORMFEED);    // second one reaches rows-2 and scrolls
   endtask

   // rows below the minimum count as three; zero columns drops every write
   // and wraps on every character; then a one-column screen
   task automatic test_small_screen();
      program_screen(8'hff, 8'd0, 6'd1, 1'b0);
      send_char(8'h61);
      send_char(CH_TAB);
      send_char(CH_NEWLINE);
      send_char(CH_FORMFEED);
      program_screen(8'h00, 8'd1, 6'd3, 1'b0);
      send_char(8'h62);
      send_char(8'h63);
   endtask

   // wrap off: tabs and vertical tabs run both counters into saturation,
   // writes past the screen are dropped while the cursor keeps moving
   task automatic test_counter_saturation();
      int roll;
      program_screen(8'h3c, 8'd60, 6'd10, 1'b1);
      repeat (100) begin
         roll = $urandom_range(0, 99);
         if (roll < 60)      send_char(CH_TAB);
         else if (roll < 80) send_char(CH_VTAB);
         else if (roll < 88) send_char(CH_FORMFEED);
         else                send_char(CHAR_W'($urandom_range(8'h20, 8'hff)));
      end
   endtask

   // wrap back on with the cursor far off screen: the column wraps once and
   // the long scroll run is cut to the slots left before the report
   task automatic test_off_screen_recovery();
      program_screen(8'h5a, 8'd60, 6'd5, 1'b0);
      send_char(CH_TAB);
      send_char(8'h5a);
      send_char(CH_NEWLINE);
   endtask

   // the receiver holds off for a long stretch while characters keep coming
   task automatic test_backpressure();
      holds_asked++;
      repeat (20) send_char(pick_char());
   endtask

   // several settings, extremes first, each with a run of random characters
   task automatic test_random_settings();
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: program_screen(8'h00, 8'd1, 6'd3, 1'b0);
            1: program_screen(8'hff, 8'd255, 6'd63, 1'b0);
            2: program_screen(8'($urandom), 8'd255, 6'd3, 1'b1);
            3: program_screen(8'($urandom), 8'($urandom_range(1, 40)),
                              6'($urandom_range(3, 12)), 1'b1);
            default: program_screen(8'($urandom), 8'($urandom_range(1, 255)),
                                    6'($urandom_range(3, 63)), 1'($urandom_range(0, 1)));
         endcase
         repeat (26) send_char(pick_char());
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_control_codes();
      test_small_screen();
      test_counter_saturation();
      test_off_screen_recovery();
      test_backpressure();
      test_random_settings();
      wait_idle();
      if (mismatches == 0 && due_cmds.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // run limit, far above the slowest legal run
   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

### sim.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_mac.sv
rtl/core/text_console_char_writer.sv
tb/tb.sv
